// ===== design/b32e_pkg.sv =====
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types, constants and the symbol alphabet of the base32 stream encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

  localparam int unsigned SymIdxW   = 5;
  localparam int unsigned SymW      = 7;
  localparam int unsigned GroupMax  = 3;
  localparam int unsigned LoBitsW   = 4;
  localparam int unsigned LoCntW    = 3;
  localparam int unsigned GrpCntW   = 2;
  localparam int unsigned GrpPosW   = 2;

  typedef logic [SymIdxW-1:0] sym_idx_t;
  typedef logic [SymW-1:0]    sym_char_t;

  typedef struct packed {
    sym_idx_t [GroupMax-1:0] sym;
    logic [GrpCntW-1:0]      cnt;
    logic                    last;
  } slice_t;

  function automatic sym_char_t b32e_char(input sym_idx_t idx);
    sym_char_t ch;
    case (idx)
      5'd0:    ch = 7'd65;
      5'd1:    ch = 7'd66;
      5'd2:    ch = 7'd67;
      5'd3:    ch = 7'd68;
      5'd4:    ch = 7'd69;
      5'd5:    ch = 7'd70;
      5'd6:    ch = 7'd71;
      5'd7:    ch = 7'd72;
      5'd8:    ch = 7'd73;
      5'd9:    ch = 7'd74;
      5'd10:   ch = 7'd75;
      5'd11:   ch = 7'd77;
      5'd12:   ch = 7'd78;
      5'd13:   ch = 7'd80;
      5'd14:   ch = 7'd81;
      5'd15:   ch = 7'd82;
      5'd16:   ch = 7'd83;
      5'd17:   ch = 7'd84;
      5'd18:   ch = 7'd85;
      5'd19:   ch = 7'd86;
      5'd20:   ch = 7'd87;
      5'd21:   ch = 7'd88;
      5'd22:   ch = 7'd89;
      5'd23:   ch = 7'd90;
      5'd24:   ch = 7'd50;
      5'd25:   ch = 7'd51;
      5'd26:   ch = 7'd52;
      5'd27:   ch = 7'd53;
      5'd28:   ch = 7'd54;
      5'd29:   ch = 7'd55;
      5'd30:   ch = 7'd56;
      default: ch = 7'd57;
    endcase
    return ch;
  endfunction

endpackage

// ===== design/b32e_if.sv =====
// ----------------------------------------------------------------------------
// b32e_if
// Valid/ready channel interfaces for the byte input and the symbol output.
// ----------------------------------------------------------------------------
interface b32e_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface b32e_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] symbol;
  logic       last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

// ===== design/b32e_slicer.sv =====
// ----------------------------------------------------------------------------
// b32e_slicer
// Joins a byte below the leftover bits and cuts it into 5-bit symbol indices.
// ----------------------------------------------------------------------------
module b32e_slicer
  import b32e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output slice_t     slice
);

  logic [LoBitsW-1:0] lo_bits_r, lo_bits_nxt;
  logic [LoCntW-1:0]  lo_cnt_r, lo_cnt_nxt;
  logic [11:0]        acc;
  sym_idx_t           s0, s1, pad;
  logic [LoBitsW-1:0] rem_v;
  logic [LoCntW-1:0]  nrem;
  logic               two_full;

  always_comb begin
    acc      = 12'd0;
    s0       = '0;
    s1       = '0;
    pad      = '0;
    rem_v    = '0;
    nrem     = '0;
    two_full = 1'b0;
    case (lo_cnt_r)
      3'd0: begin
        acc   = {4'd0, data_byte};
        s0    = acc[7:3];
        rem_v = {1'b0, acc[2:0]};
        pad   = {acc[2:0], 2'b00};
        nrem  = 3'd3;
      end
      3'd1: begin
        acc   = {3'd0, lo_bits_r[0], data_byte};
        s0    = acc[8:4];
        rem_v = acc[3:0];
        pad   = {acc[3:0], 1'b0};
        nrem  = 3'd4;
      end
      3'd2: begin
        acc      = {2'd0, lo_bits_r[1:0], data_byte};
        s0       = acc[9:5];
        s1       = acc[4:0];
        two_full = 1'b1;
      end
      3'd3: begin
        acc      = {1'b0, lo_bits_r[2:0], data_byte};
        s0       = acc[10:6];
        s1       = acc[5:1];
        rem_v    = {3'd0, acc[0]};
        pad      = {acc[0], 4'd0};
        nrem     = 3'd1;
        two_full = 1'b1;
      end
      default: begin
        acc      = {lo_bits_r, data_byte};
        s0       = acc[11:7];
        s1       = acc[6:2];
        rem_v    = {2'd0, acc[1:0]};
        pad      = {acc[1:0], 3'd0};
        nrem     = 3'd2;
        two_full = 1'b1;
      end
    endcase
  end

  always_comb begin
    slice.sym[0] = s0;
    slice.sym[1] = two_full ? s1 : pad;
    slice.sym[2] = pad;
    slice.last   = last_byte;
    if (two_full) begin
      slice.cnt = (last_byte && nrem != '0) ? 2'd3 : 2'd2;
    end else begin
      slice.cnt = (last_byte && nrem != '0) ? 2'd2 : 2'd1;
    end
    lo_bits_nxt = lo_bits_r;
    lo_cnt_nxt  = lo_cnt_r;
    if (take) begin
      lo_bits_nxt = last_byte ? '0 : rem_v;
      lo_cnt_nxt  = last_byte ? '0 : nrem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_bits_r <= '0;
      lo_cnt_r  <= '0;
    end else begin
      lo_bits_r <= lo_bits_nxt;
      lo_cnt_r  <= lo_cnt_nxt;
    end
  end

endmodule

// ===== design/b32e_symbol_queue.sv =====
// ----------------------------------------------------------------------------
// b32e_symbol_queue
// Holds the symbol group of one byte and sends it out one symbol per cycle while the output is ready.
// ----------------------------------------------------------------------------
module b32e_symbol_queue
  import b32e_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  slice_t    slice,
  output logic      load_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output sym_char_t out_symbol,
  output logic      out_last
);

  sym_idx_t [GroupMax-1:0] grp_sym_r, grp_sym_nxt;
  logic [GrpCntW-1:0]      grp_cnt_r, grp_cnt_nxt;
  logic [GrpPosW-1:0]      grp_pos_r, grp_pos_nxt;
  logic                    grp_last_r, grp_last_nxt;
  logic                    out_valid_r, out_valid_nxt;
  sym_char_t               out_sym_r, out_sym_nxt;
  logic                    out_last_r, out_last_nxt;
  logic                    pop;
  sym_idx_t                head;

  always_comb begin
    case (grp_pos_r)
      2'd0:    head = grp_sym_r[0];
      2'd1:    head = grp_sym_r[1];
      default: head = grp_sym_r[2];
    endcase
  end

  assign pop        = (grp_cnt_r != '0) && (!out_valid_r || out_ready);
  assign load_ready = (grp_cnt_r == '0) || ((grp_cnt_r == 2'd1) && pop);

  always_comb begin
    grp_sym_nxt   = grp_sym_r;
    grp_cnt_nxt   = grp_cnt_r;
    grp_pos_nxt   = grp_pos_r;
    grp_last_nxt  = grp_last_r;
    out_valid_nxt = out_valid_r;
    out_sym_nxt   = out_sym_r;
    out_last_nxt  = out_last_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
      out_sym_nxt   = b32e_char(head);
      out_last_nxt  = grp_last_r && (grp_cnt_r == 2'd1);
      grp_cnt_nxt   = grp_cnt_r - 2'd1;
      grp_pos_nxt   = grp_pos_r + 2'd1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      grp_sym_nxt  = slice.sym;
      grp_cnt_nxt  = slice.cnt;
      grp_pos_nxt  = '0;
      grp_last_nxt = slice.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_cnt_r   <= '0;
      grp_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      grp_cnt_r   <= grp_cnt_nxt;
      grp_pos_r   <= grp_pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    grp_sym_r  <= grp_sym_nxt;
    grp_last_r <= grp_last_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_symbol = out_sym_r;
  assign out_last   = out_last_r;

endmodule

// ===== design/base32_stream_encoder_core.sv =====
// ----------------------------------------------------------------------------
// base32_stream_encoder_core
// The first symbol of a byte goes from the group register into the output register.
// Rate: one symbol per cycle from the group register while the output is ready, so a
// byte gives one to three symbols, about 1.6 on average over a long message.
// Reset (synchronous, active low) clears the leftover bits and all pending symbols.
// ----------------------------------------------------------------------------
module base32_stream_encoder_core
  import b32e_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  b32e_in_if.sink    in_bus,
  b32e_out_if.source out_bus
);

  slice_t slice;
  logic   take;
  logic   load_ready;

  assign take         = in_bus.valid && load_ready;
  assign in_bus.ready = load_ready;

  b32e_slicer u_slicer (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_bus.data_byte),
    .last_byte (in_bus.last_byte),
    .slice     (slice)
  );

  b32e_symbol_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take),
    .slice      (slice),
    .load_ready (load_ready),
    .out_valid  (out_bus.valid),
    .out_ready  (out_bus.ready),
    .out_symbol (out_bus.symbol),
    .out_last   (out_bus.last_symbol)
  );

endmodule

// ===== dv/b32e_symbol_checker.sv =====
// ----------------------------------------------------------------------------
// b32e_symbol_checker
// Watches the byte and symbol channels of the base32 stream encoder. Every
// accepted byte is encoded here into the symbols it should produce. Each
// accepted symbol is then compared with the oldest symbol still due. The
// number of mismatches and the number of symbols still due go to the top.
// ----------------------------------------------------------------------------
module b32e_symbol_checker
  import b32e_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  b32e_in_if          in_bus,
  b32e_out_if         out_bus,
  output int unsigned mismatches,
  output int unsigned symbols_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [8*32-1:0] Alphabet = "ABCDEFGHIJKMNPQRSTUVWXYZ23456789";

  typedef struct packed {
    sym_char_t symbol;
    logic      last;
  } coded_sym_t;

  coded_sym_t         symbol_q[$];
  logic [LoBitsW-1:0] held_bits;
  logic [LoCntW-1:0]  held_cnt;

  function automatic sym_char_t glyph(input sym_idx_t idx);
    return Alphabet[8*(31-int'(idx)) +: SymW];
  endfunction

  function automatic void encode_byte(input logic [7:0] data, input logic fin);
    logic [11:0] acc;
    int          n;
    coded_sym_t  sym;
    acc = {held_bits, data};
    n   = int'(held_cnt) + 8;
    while (n >= 5) begin
      sym.symbol = glyph(sym_idx_t'(acc >> (n - 5)));
      n          = n - 5;
      sym.last   = fin && (n == 0);
      symbol_q   = {symbol_q, sym};
    end
    acc = acc & ((12'd1 << n) - 12'd1);
    if (fin) begin
      if (n > 0) begin
        sym.symbol = glyph(sym_idx_t'(acc << (5 - n)));
        sym.last   = 1'b1;
        symbol_q   = {symbol_q, sym};
      end
      held_bits = '0;
      held_cnt  = '0;
    end else begin
      held_bits = acc[LoBitsW-1:0];
      held_cnt  = LoCntW'(n);
    end
  endfunction

  always @(posedge clk) begin : monitor
    int unsigned bad;
    coded_sym_t  want;
    if (!rst_n) begin
      symbol_q.delete();
      held_bits   = '0;
      held_cnt    = '0;
      mismatches  <= 0;
      symbols_due <= 0;
    end else begin
      bad = 0;
      if (out_bus.valid && out_bus.ready) begin
        if (symbol_q.size() == 0) begin
          bad = 1;
          if (mismatches < 10) begin
            $display("%0t: unexpected symbol 0x%02h last=%0b", $realtime,
                     out_bus.symbol, out_bus.last_symbol);
          end
        end else begin
          want = symbol_q.pop_front();
          if (want.symbol !== out_bus.symbol || want.last !== out_bus.last_symbol) begin
            bad = 1;
            if (mismatches < 10) begin
              $display("%0t: symbol mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                       $realtime, want.symbol, want.last, out_bus.symbol,
                       out_bus.last_symbol);
            end
          end
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        encode_byte(in_bus.data_byte, in_bus.last_byte);
      end
      mismatches  <= mismatches + bad;
      symbols_due <= symbol_q.size();
    end
  end

endmodule

// ===== dv/base32_stream_encoder_core_tb.sv =====
// ----------------------------------------------------------------------------
// base32_stream_encoder_core_tb
// Drives byte messages into the base32 stream encoder: first short messages
// that end with every possible number of leftover bits, then random messages.
// Both channels stall at random, with one stretch that runs at full rate. The
// checker beside the block predicts and compares the symbols.
// ----------------------------------------------------------------------------
module base32_stream_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned RandomBytes = 280;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        steady;
  int unsigned idle_cycles = 0;
  int unsigned mismatches;
  int unsigned symbols_due;
  int unsigned sent;
  int unsigned msg_len;

  b32e_in_if  byte_ch ();
  b32e_out_if sym_ch ();

  base32_stream_encoder_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (byte_ch),
    .out_bus (sym_ch)
  );

  b32e_symbol_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_bus      (byte_ch),
    .out_bus     (sym_ch),
    .mismatches  (mismatches),
    .symbols_due (symbols_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    sym_ch.ready <= steady || ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (!rst_n || (byte_ch.valid && byte_ch.ready) || (sym_ch.valid && sym_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] data, input logic fin);
    logic took;
    while (!steady && $urandom_range(99) < 35) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid     <= 1'b1;
    byte_ch.data_byte <= data;
    byte_ch.last_byte <= fin;
    do begin
      @(negedge clk);
      took = byte_ch.ready;
      @(posedge clk);
    end while (!took);
  endtask

  initial begin
    rst_n             = 1'b0;
    steady            = 1'b0;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = 8'h00;
    byte_ch.last_byte = 1'b0;
    sym_ch.ready      = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // One-byte messages leave three bits for a padded symbol.
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    // Two bytes end with three symbols, the last padded from one bit.
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    // Three bytes leave four bits, four bytes leave two.
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h0F, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'hCC, 1'b0);
    send_byte(8'h5A, 1'b1);
    // Five bytes end exactly on a symbol, so no padded symbol follows.
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);

    sent = 0;
    while (sent < RandomBytes) begin
      steady  <= (sent >= 100) && (sent < 170);
      msg_len = ($urandom_range(9) == 0) ? $urandom_range(24, 13) : $urandom_range(8, 1);
      for (int i = 0; i < msg_len; i++) begin
        case ($urandom_range(9))
          0:       send_byte(8'h00, i == msg_len - 1);
          1:       send_byte(8'hFF, i == msg_len - 1);
          default: send_byte(8'($urandom_range(255)), i == msg_len - 1);
        endcase
        sent++;
      end
    end

    byte_ch.valid <= 1'b0;
    steady        <= 1'b0;
    do @(posedge clk); while (symbols_due != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
